>>> hw/rtl/lfct_pkg.sv
// Package for the log-frequency curve table: action codes, sequencer states, constants.
`default_nettype none
package lfct_pkg;

   // action code of an input word
   typedef enum logic [2:0] {
      ACT_CLEAR   = 3'd0,
      ACT_APPEND  = 3'd1,
      ACT_SET     = 3'd2,
      ACT_REMOVE  = 3'd3,
      ACT_LOOKUP  = 3'd4,
      ACT_OVERLAP = 3'd5
   } action_type;

   // sequencer states
   typedef enum logic [4:0] {
      S_IDLE,
      S_APPEND,
      S_SETV,
      S_REMOVE,
      S_OVL_FIRST,
      S_OVL_LAST,
      S_LK_FIRST,
      S_LK_LAST,
      S_BS,
      S_BS_CMP,
      S_HIT,
      S_LEFT,
      S_LOG_NORM,
      S_LOG_SQ,
      S_SPAN,
      S_DIV,
      S_MUL,
      S_SUM,
      S_RESP
   } state_type;

   localparam int INTERP_FRAC_BITS = 16;
   localparam int FRAC_WIDTH       = 17;
   localparam int LOG_INT_BITS     = 5;

endpackage
`default_nettype wire

>>> hw/rtl/log_frequency_curve_table_core.sv
// Log-frequency curve table: point store, binary search, log2 interpolation sequencer.
// A lookup runs the log2 unit (one shift per cycle, one square per cycle) three times,
// then the one-bit-per-cycle divider. One word at a time: busy is high from acceptance
// through the strobe, so a new word is not accepted until the previous one is answered.
// Synchronous reset empties the table (point count and nonzero count to zero); no receiver stall.
`default_nettype none
module log_frequency_curve_table_core #(
   parameter int TABLE_DEPTH       = 64,
   parameter int LOG_FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_action,
   input  logic [31:0]        req_freq_a,
   input  logic [31:0]        req_freq_b,
   input  logic [5:0]         req_point_index,
   input  logic signed [31:0] req_point_value,
   output logic               rsp_strobe,
   output logic               rsp_ok,
   output logic signed [31:0] rsp_result_value,
   output logic [6:0]         rsp_point_count,
   output logic               rsp_is_neutral
);
   import lfct_pkg::*;

   localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW  = $clog2(TABLE_DEPTH + 1);
   localparam int PW  = (CW > 6) ? CW : 6;
   localparam int LFB = LOG_FRACTION_BITS;
   localparam int LW  = LOG_INT_BITS + LFB;
   localparam int NW  = LW + INTERP_FRAC_BITS;
   localparam int LBW = $clog2(LFB);
   localparam int DCW = $clog2(NW);

   // point memories
   logic [31:0]        freq_mem [TABLE_DEPTH];
   logic signed [31:0] val_mem  [TABLE_DEPTH];
   logic [31:0]        freq_rd_ff;
   logic signed [31:0] val_rd_ff;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic               wr_freq_en, wr_val_en;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, nz_ff, nz_in;
   logic [2:0]    action_ff, action_in;
   logic [31:0]   fa_ff, fa_in, fb_ff, fb_in, first_ff, first_in, fr_ff, fr_in;
   logic [5:0]    pidx_ff, pidx_in;
   logic signed [31:0] pv_ff, pv_in, vl_ff, vl_in, vr_ff, vr_in, res_ff, res_in;
   logic          ok_ff, ok_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [31:0]   lx_ff, lx_in, lm_ff, lm_in;
   logic [LOG_INT_BITS-1:0] ln_ff, ln_in;
   logic [LFB-1:0] lfrac_ff, lfrac_in;
   logic [LBW-1:0] lbit_ff, lbit_in;
   logic [1:0]     lsel_ff, lsel_in;
   logic [LW-1:0]  ll_ff, ll_in, lr_ff, lr_in, lf_ff, lf_in, span_ff, span_in, rem_ff, rem_in;
   logic [NW-1:0]  num_ff, num_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   logic signed [50:0] prod_ff, prod_in;

   // combinational helpers
   logic [CW-1:0]  mid, idx_clamp;
   logic [63:0]    sq;
   logic [32:0]    sq_t;
   logic [LFB-1:0] frac_next;
   logic [LW-1:0]  lres, lf_use;
   logic [LW:0]    div_r;
   logic           div_ge;
   logic signed [32:0] delta;
   logic signed [35:0] sum;

   // memory ports
   always_ff @(posedge clock) begin
      freq_rd_ff <= freq_mem[rd_addr];
      val_rd_ff  <= val_mem[rd_addr];
      if (wr_freq_en) freq_mem[wr_addr] <= fa_ff;
      if (wr_val_en) val_mem[wr_addr] <= pv_ff;
   end

   // state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         nz_ff    <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         nz_ff    <= nz_in;
      end
      action_ff <= action_in;
      fa_ff     <= fa_in;
      fb_ff     <= fb_in;
      pidx_ff   <= pidx_in;
      pv_ff     <= pv_in;
      first_ff  <= first_in;
      fr_ff     <= fr_in;
      vl_ff     <= vl_in;
      vr_ff     <= vr_in;
      res_ff    <= res_in;
      ok_ff     <= ok_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      idx_ff    <= idx_in;
      lx_ff     <= lx_in;
      lm_ff     <= lm_in;
      ln_ff     <= ln_in;
      lfrac_ff  <= lfrac_in;
      lbit_ff   <= lbit_in;
      lsel_ff   <= lsel_in;
      ll_ff     <= ll_in;
      lr_ff     <= lr_in;
      lf_ff     <= lf_in;
      span_ff   <= span_in;
      rem_ff    <= rem_in;
      num_ff    <= num_in;
      dcnt_ff   <= dcnt_in;
      prod_ff   <= prod_in;
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      nz_in     = nz_ff;
      action_in = action_ff;
      fa_in     = fa_ff;
      fb_in     = fb_ff;
      pidx_in   = pidx_ff;
      pv_in     = pv_ff;
      first_in  = first_ff;
      fr_in     = fr_ff;
      vl_in     = vl_ff;
      vr_in     = vr_ff;
      res_in    = res_ff;
      ok_in     = ok_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      idx_in    = idx_ff;
      lx_in     = lx_ff;
      lm_in     = lm_ff;
      ln_in     = ln_ff;
      lfrac_in  = lfrac_ff;
      lbit_in   = lbit_ff;
      lsel_in   = lsel_ff;
      ll_in     = ll_ff;
      lr_in     = lr_ff;
      lf_in     = lf_ff;
      span_in   = span_ff;
      rem_in    = rem_ff;
      num_in    = num_ff;
      dcnt_in   = dcnt_ff;
      prod_in   = prod_ff;
      rd_addr   = '0;
      wr_addr   = '0;
      wr_freq_en = 1'b0;
      wr_val_en  = 1'b0;

      mid       = lo_ff + ((hi_ff - lo_ff) >> 1);
      idx_clamp = (lo_ff >= count_ff) ? count_ff - 1'b1 : lo_ff;
      sq        = 64'(lm_ff) * 64'(lm_ff);
      sq_t      = sq[63:31];
      frac_next = {lfrac_ff[LFB-2:0], sq_t[32]};
      lres      = {ln_ff, frac_next};
      lf_use    = (lf_ff < ll_ff) ? ll_ff : lf_ff;
      div_r     = {rem_ff, num_ff[NW-1]};
      div_ge    = div_r >= {1'b0, span_ff};
      delta     = 33'(vr_ff) - 33'(vl_ff);
      sum       = 36'(vl_ff) + 36'(prod_ff >>> INTERP_FRAC_BITS);

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               action_in = req_action;
               fa_in     = req_freq_a;
               fb_in     = req_freq_b;
               pidx_in   = req_point_index;
               pv_in     = req_point_value;
               ok_in     = 1'b0;
               res_in    = '0;
               case (action_type'(req_action))
                  ACT_CLEAR: begin
                     count_in = '0;
                     nz_in    = '0;
                     ok_in    = 1'b1;
                     state_in = S_RESP;
                  end
                  ACT_APPEND: begin
                     rd_addr  = AW'(count_ff - 1'b1);
                     state_in = S_APPEND;
                  end
                  ACT_SET: begin
                     rd_addr  = AW'(req_point_index);
                     state_in = S_SETV;
                  end
                  ACT_REMOVE: begin
                     rd_addr  = AW'(count_ff - 1'b1);
                     state_in = S_REMOVE;
                  end
                  ACT_LOOKUP:  state_in = S_LK_FIRST;
                  ACT_OVERLAP: state_in = S_OVL_FIRST;
                  default:     state_in = S_RESP;
               endcase
            end
         end
         S_APPEND: begin
            if (fa_ff != 0 && count_ff < CW'(TABLE_DEPTH) &&
                (count_ff == 0 || fa_ff > freq_rd_ff)) begin
               wr_addr    = AW'(count_ff);
               wr_freq_en = 1'b1;
               wr_val_en  = 1'b1;
               count_in   = count_ff + 1'b1;
               nz_in      = nz_ff + CW'(pv_ff != 0);
               ok_in      = 1'b1;
            end
            state_in = S_RESP;
         end
         S_SETV: begin
            if (PW'(pidx_ff) < PW'(count_ff)) begin
               wr_addr   = AW'(pidx_ff);
               wr_val_en = 1'b1;
               nz_in     = nz_ff - CW'(val_rd_ff != 0) + CW'(pv_ff != 0);
               ok_in     = 1'b1;
            end
            state_in = S_RESP;
         end
         S_REMOVE: begin
            if (count_ff != 0) begin
               count_in = count_ff - 1'b1;
               nz_in    = nz_ff - CW'(val_rd_ff != 0);
               ok_in    = 1'b1;
            end
            state_in = S_RESP;
         end
         S_OVL_FIRST: begin
            first_in = freq_rd_ff;
            rd_addr  = AW'(count_ff - 1'b1);
            state_in = S_OVL_LAST;
         end
         S_OVL_LAST: begin
            ok_in = count_ff != 0 && fa_ff != 0 && fb_ff >= fa_ff &&
                    freq_rd_ff >= fa_ff && first_ff <= fb_ff;
            state_in = S_RESP;
         end
         S_LK_FIRST: begin
            first_in = freq_rd_ff;
            rd_addr  = AW'(count_ff - 1'b1);
            state_in = S_LK_LAST;
         end
         // range check, then open the search window
         S_LK_LAST: begin
            if (fa_ff == 0 || count_ff < CW'(2) || fa_ff < first_ff || fa_ff > freq_rd_ff) begin
               state_in = S_RESP;
            end else begin
               lo_in    = '0;
               hi_in    = count_ff;
               state_in = S_BS;
            end
         end
         S_BS: begin
            if (lo_ff < hi_ff) begin
               rd_addr  = AW'(mid);
               state_in = S_BS_CMP;
            end else begin
               rd_addr  = AW'(idx_clamp);
               idx_in   = AW'(idx_clamp);
               state_in = S_HIT;
            end
         end
         S_BS_CMP: begin
            if (freq_rd_ff < fa_ff) lo_in = mid + 1'b1;
            else hi_in = mid;
            state_in = S_BS;
         end
         // exact hit or first point returns the stored value
         S_HIT: begin
            if (freq_rd_ff == fa_ff || idx_ff == 0) begin
               ok_in    = 1'b1;
               res_in   = val_rd_ff;
               state_in = S_RESP;
            end else begin
               fr_in    = freq_rd_ff;
               vr_in    = val_rd_ff;
               rd_addr  = idx_ff - 1'b1;
               state_in = S_LEFT;
            end
         end
         S_LEFT: begin
            vl_in    = val_rd_ff;
            lx_in    = freq_rd_ff;
            ln_in    = '1;
            lfrac_in = '0;
            lsel_in  = '0;
            state_in = S_LOG_NORM;
         end
         // log2: normalize one bit per cycle
         S_LOG_NORM: begin
            if (lx_ff[31]) begin
               lm_in    = lx_ff;
               lbit_in  = '0;
               state_in = S_LOG_SQ;
            end else begin
               lx_in = lx_ff << 1;
               ln_in = ln_ff - 1'b1;
            end
         end
         // log2: one square per fraction bit
         S_LOG_SQ: begin
            lfrac_in = frac_next;
            lm_in    = sq_t[32] ? sq_t[32:1] : sq_t[31:0];
            lbit_in  = lbit_ff + 1'b1;
            if (lbit_ff == LBW'(LFB - 1)) begin
               ln_in    = '1;
               lfrac_in = '0;
               lsel_in  = lsel_ff + 1'b1;
               state_in = S_LOG_NORM;
               case (lsel_ff)
                  2'd0: begin
                     ll_in = lres;
                     lx_in = fr_ff;
                  end
                  2'd1: begin
                     lr_in = lres;
                     lx_in = fa_ff;
                  end
                  default: begin
                     lf_in    = lres;
                     state_in = S_SPAN;
                  end
               endcase
            end
         end
         S_SPAN: begin
            if (lr_ff <= ll_ff) begin
               state_in = S_RESP;
            end else begin
               span_in  = lr_ff - ll_ff;
               num_in   = {lf_use - ll_ff, {INTERP_FRAC_BITS{1'b0}}};
               rem_in   = '0;
               dcnt_in  = '0;
               state_in = S_DIV;
            end
         end
         // restoring divide, one quotient bit per cycle
         S_DIV: begin
            rem_in  = div_ge ? LW'(div_r - {1'b0, span_ff}) : LW'(div_r);
            num_in  = {num_ff[NW-2:0], div_ge};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCW'(NW - 1)) state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = $signed({1'b0, num_ff[FRAC_WIDTH-1:0]}) * delta;
            state_in = S_SUM;
         end
         // floor, add and saturate
         S_SUM: begin
            ok_in = 1'b1;
            if (sum > 36'sd2147483647) res_in = 32'sh7fffffff;
            else if (sum < -36'sd2147483648) res_in = 32'sh80000000;
            else res_in = 32'(sum);
            state_in = S_RESP;
         end
         S_RESP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign busy             = state_ff != S_IDLE;
   assign rsp_strobe       = state_ff == S_RESP;
   assign rsp_ok           = ok_ff;
   assign rsp_result_value = res_ff;
   assign rsp_point_count  = 7'(count_ff);
   assign rsp_is_neutral   = nz_ff == 0;

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// Testbench for the log-frequency curve table core: queued driver, strobe monitor, predictor.
`default_nettype none
module tb;
   import lfct_pkg::*;

   localparam int DEPTH = 64;
   localparam int LFB   = 16;
   localparam int LIMIT_CYCLES = 2000000;
   localparam logic [2:0] ACT_BAD6 = 3'd6;
   localparam logic [2:0] ACT_BAD7 = 3'd7;

   typedef struct packed {
      logic [2:0]         action;
      logic [31:0]        freq_a;
      logic [31:0]        freq_b;
      logic [5:0]         point_index;
      logic signed [31:0] point_value;
   } cmd_word_type;

   typedef struct packed {
      logic               ok;
      logic signed [31:0] value;
      logic [6:0]         count;
      logic               neutral;
   } rsp_word_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [2:0] req_action = '0;
   logic [31:0] req_freq_a = '0;
   logic [31:0] req_freq_b = '0;
   logic [5:0] req_point_index = '0;
   logic signed [31:0] req_point_value = '0;
   logic rsp_strobe, rsp_ok, rsp_is_neutral;
   logic signed [31:0] rsp_result_value;
   logic [6:0] rsp_point_count;

   log_frequency_curve_table_core u_top (.*);

   // predictor state
   logic [31:0] curve_freq [DEPTH];
   logic signed [31:0] curve_val [DEPTH];
   int curve_count = 0;
   int curve_nonzero = 0;

   cmd_word_type pending_cmds[$];
   rsp_word_type expected_rsps[$];
   int mismatches = 0;
   int cycles = 0;
   int send_idle_pct = 19;
   bit hold_send = 0;
   bit stim_done = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // log2 with LFB fraction bits by repeated squaring
   function automatic logic [63:0] log2_fx(input logic [31:0] x);
      int n;
      logic [63:0] m, frac;
      n = 31;
      while (n > 0 && x[n] == 1'b0) n--;
      m = 64'(x) << (31 - n);
      frac = 0;
      for (int i = 0; i < LFB; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            frac[0] = 1'b1;
            m = m >> 1;
         end
      end
      return (64'(n) << LFB) | frac;
   endfunction

   function automatic logic signed [63:0] floor_q16(input logic signed [63:0] p);
      return p >>> 16;
   endfunction

   function automatic bit interp_lookup(input logic [31:0] f,
                                        output logic signed [31:0] res);
      int lo, hi, mid, idx;
      logic [63:0] ll, lr, lf, span, frac;
      logic signed [63:0] delta, r;
      res = 0;
      if (f == 0 || curve_count < 2) return 0;
      if (f < curve_freq[0] || f > curve_freq[curve_count-1]) return 0;
      lo = 0; hi = curve_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (curve_freq[mid] < f) lo = mid + 1;
         else hi = mid;
      end
      idx = (lo >= curve_count) ? curve_count - 1 : lo;
      if (curve_freq[idx] == f || idx == 0) begin
         res = curve_val[idx];
         return 1;
      end
      ll = log2_fx(curve_freq[idx-1]);
      lr = log2_fx(curve_freq[idx]);
      lf = log2_fx(f);
      if (lr <= ll) return 0;
      span = lr - ll;
      if (lf < ll) lf = ll;
      frac = ((lf - ll) << 16) / span;
      delta = 64'(curve_val[idx]) - 64'(curve_val[idx-1]);
      r = 64'(curve_val[idx-1]) + floor_q16($signed(frac) * delta);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      res = r[31:0];
      return 1;
   endfunction

   function automatic rsp_word_type predict_table(input cmd_word_type c);
      rsp_word_type e;
      logic signed [31:0] v;
      e = '0;
      case (c.action)
         ACT_CLEAR: begin
            curve_count = 0; curve_nonzero = 0; e.ok = 1;
         end
         ACT_APPEND:
            if (c.freq_a != 0 && curve_count < DEPTH &&
                (curve_count == 0 || c.freq_a > curve_freq[curve_count-1])) begin
               curve_freq[curve_count] = c.freq_a;
               curve_val[curve_count] = c.point_value;
               curve_count++;
               if (c.point_value != 0) curve_nonzero++;
               e.ok = 1;
            end
         ACT_SET:
            if (c.point_index < curve_count) begin
               if (curve_val[c.point_index] != 0) curve_nonzero--;
               curve_val[c.point_index] = c.point_value;
               if (c.point_value != 0) curve_nonzero++;
               e.ok = 1;
            end
         ACT_REMOVE:
            if (curve_count > 0) begin
               curve_count--;
               if (curve_val[curve_count] != 0) curve_nonzero--;
               e.ok = 1;
            end
         ACT_LOOKUP: begin
            e.ok = interp_lookup(c.freq_a, v);
            e.value = e.ok ? v : 32'sd0;
         end
         ACT_OVERLAP:
            if (curve_count > 0 && c.freq_a != 0 && c.freq_b >= c.freq_a)
               e.ok = curve_freq[curve_count-1] >= c.freq_a && curve_freq[0] <= c.freq_b;
         default: ;
      endcase
      e.count = 7'(curve_count);
      e.neutral = (curve_nonzero == 0);
      return e;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
   endtask

   // driver: one word per accepted start
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            expected_rsps.push_back(predict_table({req_action, req_freq_a, req_freq_b,
                                                   req_point_index, req_point_value}));
            void'(pending_cmds.pop_front());
         end
         if (pending_cmds.size() > (start && !busy ? 1 : 0) && !hold_send &&
             $urandom_range(99) >= send_idle_pct) begin
            cmd_word_type c;
            c = (start && !busy) ? pending_cmds[1] : pending_cmds[0];
            start <= 1;
            req_action <= c.action;
            req_freq_a <= c.freq_a;
            req_freq_b <= c.freq_b;
            req_point_index <= c.point_index;
            req_point_value <= c.point_value;
         end else if (start && !busy) begin
            start <= 0;
         end
      end
   end

   // monitor: compare each strobed word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected word", 0, 0);
         end else begin
            rsp_word_type e;
            e = expected_rsps.pop_front();
            if (rsp_ok !== e.ok) report_mismatch("ok", rsp_ok, e.ok);
            if (rsp_result_value !== e.value)
               report_mismatch("result_value", rsp_result_value, e.value);
            if (rsp_point_count !== e.count)
               report_mismatch("point_count", rsp_point_count, e.count);
            if (rsp_is_neutral !== e.neutral)
               report_mismatch("is_neutral", rsp_is_neutral, e.neutral);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic cmd_word_type mk(input logic [2:0] a, input logic [31:0] fa,
                                       input logic [31:0] fb, input logic [5:0] pi,
                                       input logic [31:0] pv);
      return {a, fa, fb, pi, pv};
   endfunction

   function automatic logic [31:0] rand_value();
      case ($urandom_range(5))
         0: return 32'h0;
         1: return 32'h7fff_ffff;
         2: return 32'h8000_0000;
         3: return $urandom_range(0, 1) ? 32'(-$urandom_range(0, 65536*8))
                                         : 32'($urandom_range(0, 65536*8));
         default: return $urandom;
      endcase
   endfunction

   // queue a random well-formed curve followed by queries
   task automatic queue_curve_session(input int len, input int queries);
      logic [31:0] f, fmin, fmax;
      int step_hi;
      pending_cmds.push_back(mk(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom));
      step_hi = $urandom_range(0, 1) ? 300 : 32'h0100_0000;
      f = $urandom_range(1, 5000);
      fmin = f;
      fmax = f;
      for (int i = 0; i < len; i++) begin
         pending_cmds.push_back(mk(ACT_APPEND, f, $urandom, $urandom, rand_value()));
         fmax = f;
         if (f > 32'hF000_0000) break;
         f = f + $urandom_range(1, step_hi);
      end
      for (int q = 0; q < queries; q++) begin
         case ($urandom_range(9))
            0: pending_cmds.push_back(mk(ACT_SET, $urandom, $urandom,
                                         $urandom_range(0, len), rand_value()));
            1: pending_cmds.push_back(mk(ACT_REMOVE, $urandom, $urandom, $urandom, $urandom));
            2: pending_cmds.push_back(mk(ACT_OVERLAP, $urandom_range(0, fmax + 10),
                                         $urandom_range(fmin > 10 ? fmin - 10 : 0, 32'hffff_ffff),
                                         $urandom, $urandom));
            3: pending_cmds.push_back(mk(ACT_APPEND, $urandom_range(0, 1) ? $urandom : f,
                                         $urandom, $urandom, rand_value()));
            4: pending_cmds.push_back(mk($urandom_range(0, 7), $urandom, $urandom,
                                         $urandom, $urandom));
            default: pending_cmds.push_back(mk(ACT_LOOKUP,
                                               $urandom_range(fmin > 5 ? fmin - 5 : 0, fmax + 5),
                                               $urandom, $urandom, $urandom));
         endcase
      end
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() != 0 || start || busy || expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   // stimulus
   initial begin
      int sent;
      repeat (11) @(posedge clock);
      reset <= 0;
      // directed
      pending_cmds.push_back(mk(ACT_REMOVE, 0, 0, 0, 0));
      pending_cmds.push_back(mk(ACT_LOOKUP, 100, 0, 0, 0));
      pending_cmds.push_back(mk(ACT_OVERLAP, 1, 32'hffff_ffff, 0, 0));
      pending_cmds.push_back(mk(ACT_SET, 0, 0, 0, 5));
      pending_cmds.push_back(mk(ACT_APPEND, 0, 0, 0, 1));
      pending_cmds.push_back(mk(ACT_APPEND, 256, 0, 0, 32'h7fff_ffff));
      pending_cmds.push_back(mk(ACT_LOOKUP, 256, 0, 0, 0));
      pending_cmds.push_back(mk(ACT_APPEND, 256, 0, 0, 0));
      pending_cmds.push_back(mk(ACT_APPEND, 257, 0, 0, 32'h8000_0000));
      pending_cmds.push_back(mk(ACT_LOOKUP, 257, 0, 0, 0));
      pending_cmds.push_back(mk(ACT_APPEND, 1024, 0, 0, 32'h7fff_ffff));
      pending_cmds.push_back(mk(ACT_LOOKUP, 600, 0, 0, 0));
      pending_cmds.push_back(mk(ACT_LOOKUP, 0, 0, 0, 0));
      pending_cmds.push_back(mk(ACT_LOOKUP, 2000, 0, 0, 0));
      pending_cmds.push_back(mk(ACT_APPEND, 32'hffff_ffff, 0, 0, 0));
      pending_cmds.push_back(mk(ACT_LOOKUP, 32'hffff_fff0, 0, 0, 0));
      pending_cmds.push_back(mk(ACT_OVERLAP, 0, 10, 0, 0));
      pending_cmds.push_back(mk(ACT_OVERLAP, 500, 400, 0, 0));
      pending_cmds.push_back(mk(ACT_OVERLAP, 1, 255, 0, 0));
      pending_cmds.push_back(mk(ACT_SET, 0, 0, 63, 0));
      pending_cmds.push_back(mk(ACT_SET, 0, 0, 3, 0));
      pending_cmds.push_back(mk(ACT_BAD6, 0, 0, 0, 0));
      pending_cmds.push_back(mk(ACT_BAD7, 0, 0, 0, 0));
      pending_cmds.push_back(mk(ACT_CLEAR, 0, 0, 0, 0));
      // full table: 64 points plus one rejected
      for (int i = 0; i < 65; i++)
         pending_cmds.push_back(mk(ACT_APPEND, 32'(1 + i * 3), 0, 0, 32'(i)));
      pending_cmds.push_back(mk(ACT_LOOKUP, 95, 0, 0, 0));
      wait_drained();
      // random phases with different idle mixes
      sent = 0;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 55 : 0;
         while (sent < 650 * (phase + 1)) begin
            int len, qn;
            len = ($urandom_range(9) == 0) ? $urandom_range(30, 64) : $urandom_range(0, 8);
            qn = $urandom_range(4, 20);
            queue_curve_session(len, qn);
            sent += len + qn + 1;
            if ($urandom_range(7) == 0) begin
               // hold off until every expected word has come
               while (pending_cmds.size() != 0 || start || busy || expected_rsps.size() != 0)
                  @(posedge clock);
               hold_send = 1;
               repeat ($urandom_range(1, 20)) @(posedge clock);
               hold_send = 0;
            end else begin
               while (pending_cmds.size() > 40) @(posedge clock);
            end
         end
      end
      wait_drained();
      repeat (400) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> sim.f
hw/rtl/lfct_pkg.sv
hw/rtl/log_frequency_curve_table_core.sv
tb/sv/tb.sv
